FILE: rtl/core/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg: shared widths, types and helpers for the segment intersection core
// Coordinates, cross-product widths, divider lane layout and result kinds.
// ----------------------------------------------------------------------------
package sip_pkg;

    // Coordinate format and fixed-point result format
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // Stream field layout
    localparam int IN_W       = 16;
    localparam int N_IN       = 8;
    localparam int IN_DATA_W  = N_IN * IN_W;
    localparam int OUT_W      = 32;
    localparam int OUT_DATA_W = 2 * OUT_W;
    localparam int KIND_W     = 3;
    localparam int USER_W     = 8;

    // Datapath widths
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int PSUM_W  = CROSS_W + DIFF_W + 1;
    localparam int SH_W    = PSUM_W + FRAC_BITS;
    localparam int QUO_W   = COORD_BITS + FRAC_BITS;
    localparam int DMAG_W  = CROSS_W;
    localparam int RES_W   = (QUO_W + 1 > OUT_W) ? QUO_W + 1 : OUT_W;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CROSS   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_B_START = 3'd2;
    localparam logic [KIND_W-1:0] KIND_B_END   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_A_START = 3'd4;
    localparam logic [KIND_W-1:0] KIND_A_END   = 3'd5;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [CROSS_W-1:0]    t_cross;
    typedef logic signed [PSUM_W-1:0]     t_psum;
    typedef logic [PSUM_W-1:0]            t_mag;
    typedef logic [DMAG_W-1:0]            t_dmag;
    typedef logic [KIND_W-1:0]            t_kind;

    typedef struct packed {
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
        t_coord x3;
        t_coord y3;
        t_coord x4;
        t_coord y4;
    } t_pts;

    // Cross products and pass-along data after the orientation stages
    typedef struct packed {
        t_cross     c1;
        t_cross     c2;
        t_cross     c3;
        t_cross     c4;
        t_cross     den;
        t_diff      adx;
        t_diff      ady;
        logic [3:0] win;
        t_pts       pts;
    } t_geo;

    // Decision carried alongside the divider
    typedef struct packed {
        t_kind  kind;
        t_coord ep_x;
        t_coord ep_y;
    } t_side;

    typedef struct packed {
        t_mag  mag_x;
        t_mag  mag_y;
        logic  neg_x;
        logic  neg_y;
        t_dmag dmag;
        t_side side;
    } t_quot_req;

    typedef struct packed {
        logic [DMAG_W-1:0] rem;
        logic [QUO_W-1:0]  nq;
    } t_lane;

    typedef struct packed {
        t_lane x;
        t_lane y;
        t_dmag dmag;
        logic  neg_x;
        logic  neg_y;
        t_side side;
    } t_div_st;

    typedef struct packed {
        logic [QUO_W-1:0] quot_x;
        logic [QUO_W-1:0] quot_y;
        logic             neg_x;
        logic             neg_y;
        t_side            side;
    } t_quot_res;

    typedef struct packed {
        logic             hit;
        t_kind            kind;
        logic [OUT_W-1:0] px;
        logic [OUT_W-1:0] py;
    } t_result;

    // Take the low COORD_BITS of a field as a signed coordinate
    function automatic t_coord to_coord(input logic [IN_W-1:0] v);
        logic [IN_W+COORD_BITS-1:0] z;
        z = {{COORD_BITS{1'b0}}, v};
        return t_coord'(z[COORD_BITS-1:0]);
    endfunction

    function automatic t_pts unpack_pts(input logic [IN_DATA_W-1:0] d);
        t_pts p;
        p.x1 = to_coord(d[0*IN_W +: IN_W]);
        p.y1 = to_coord(d[1*IN_W +: IN_W]);
        p.x2 = to_coord(d[2*IN_W +: IN_W]);
        p.y2 = to_coord(d[3*IN_W +: IN_W]);
        p.x3 = to_coord(d[4*IN_W +: IN_W]);
        p.y3 = to_coord(d[5*IN_W +: IN_W]);
        p.x4 = to_coord(d[6*IN_W +: IN_W]);
        p.y4 = to_coord(d[7*IN_W +: IN_W]);
        return p;
    endfunction

endpackage

FILE: rtl/core/segment_intersection_point.sv
// ----------------------------------------------------------------------------
// segment_intersection_point: exact 2D segment intersection, Q16.16 point
// Each request carries two segments, a and b, as eight signed 16-bit
// coordinates; each produces exactly one response. Orientation signs come
// from exact cross products, so collinearity is an exact zero test. When
// the segments properly cross (or touch with differing signs on both
// sides) the response is kind "crossing" with the point p1 + t*(p2 - p1)
// in Q16.16, truncated toward zero; a zero denominator there yields no
// hit. Otherwise the endpoints are tried in the order b start, b end,
// a start, a end, and the first one that is collinear with and inside the
// box of the other segment is returned. A miss returns hit, kind and point
// all zero. The core takes one request per clock while o_s_tready is high;
// a request passes the cross products, the numerator forming, 32 divider
// stages (one quotient bit per stage, set by COORD_BITS + FRAC_BITS), one
// result stage and the output register. A skid register behind the output
// keeps requests flowing after the downstream side stalls, until it takes
// a response; the whole pipe then holds in place.
// ----------------------------------------------------------------------------
module segment_intersection_point (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request: seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
    //          seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [sip_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // response: point_x, point_y
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [sip_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // response: hit, hit_kind, zero padding
    output logic [sip_pkg::USER_W-1:0]     o_m_tuser
);
    import sip_pkg::*;

    // Global advance: every stage up to the result register moves while the skid is empty
    logic      w_en;
    t_pts      w_pts;
    logic      w_geo_valid, w_req_valid, w_res_valid;
    t_geo      w_geo;
    t_quot_req w_req;
    t_quot_res w_res;

    logic    r_fin_valid;
    t_result r_fin;
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    w_take, w_push;

    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;
    assign w_pts      = unpack_pts(i_s_tdata);

    sip_orient u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_pts   (w_pts),
        .o_valid (w_geo_valid),
        .o_geo   (w_geo)
    );

    sip_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_geo_valid),
        .i_geo   (w_geo),
        .o_valid (w_req_valid),
        .o_req   (w_req)
    );

    sip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_req_valid),
        .i_req   (w_req),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    // Result stage: sign the quotients, scale the chosen endpoint, or zero a miss
    logic [RES_W-1:0] w_qx, w_qy, w_ex, w_ey;
    t_result          n_fin;

    always_comb begin
        w_qx = RES_W'(w_res.quot_x);
        w_qy = RES_W'(w_res.quot_y);
        if (w_res.neg_x) begin
            w_qx = ~w_qx + 1'b1;
        end
        if (w_res.neg_y) begin
            w_qy = ~w_qy + 1'b1;
        end
        w_ex = RES_W'(w_res.side.ep_x) << FRAC_BITS;
        w_ey = RES_W'(w_res.side.ep_y) << FRAC_BITS;

        n_fin.kind = w_res.side.kind;
        case (w_res.side.kind)
            KIND_CROSS: begin
                n_fin.hit = 1'b1;
                n_fin.px  = w_qx[OUT_W-1:0];
                n_fin.py  = w_qy[OUT_W-1:0];
            end
            KIND_B_START, KIND_B_END, KIND_A_START, KIND_A_END: begin
                n_fin.hit = 1'b1;
                n_fin.px  = w_ex[OUT_W-1:0];
                n_fin.py  = w_ey[OUT_W-1:0];
            end
            default: begin
                n_fin.hit  = 1'b0;
                n_fin.kind = KIND_NONE;
                n_fin.px   = '0;
                n_fin.py   = '0;
            end
        endcase
    end

    assign w_take = r_out_valid && i_m_tready;
    assign w_push = w_en && r_fin_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_fin_valid <= w_res_valid;
            end
            if (w_take || !r_out_valid) begin
                // Drain the skid first; a push cannot happen while it is full
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_push;
                end
            end else if (w_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin <= n_fin;
        end
        if (w_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : r_fin;
        end else if (w_push) begin
            r_skid <= r_fin;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.py, r_out.px};
    assign o_m_tuser  = {{(USER_W - 1 - KIND_W){1'b0}}, r_out.kind, r_out.hit};

    // The skid only ever holds a response queued behind the output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // The skid fills only when the output was held by the consumer
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_tready))
        else $error("skid register filled without a downstream stall");

    // The hit flag agrees with the kind
    a_hit_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.hit == (r_out.kind != KIND_NONE)))
        else $error("hit flag disagrees with hit kind");

    // A miss carries a zero point
    a_miss_zero_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_NONE)) |-> ((r_out.px == '0) && (r_out.py == '0)))
        else $error("miss response carries a nonzero point");

endmodule

FILE: rtl/core/sip_orient.sv
// ----------------------------------------------------------------------------
// sip_orient: orientation cross products
// Three stages: coordinate differences and box tests, products, cross-product subtraction.
// ----------------------------------------------------------------------------
module sip_orient (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  sip_pkg::t_pts i_pts,
    output logic          o_valid,
    output sip_pkg::t_geo o_geo
);
    import sip_pkg::*;

    function automatic logic in_box(input t_coord v, input t_coord l1, input t_coord l2);
        return ((v >= l1) && (v <= l2)) || ((v >= l2) && (v <= l1));
    endfunction

    // Stage 1: differences and box tests
    logic       r1_valid;
    t_pts       r1_pts;
    t_diff      r1_adx, r1_ady, r1_bdx, r1_bdy;
    t_diff      r1_d13x, r1_d13y, r1_d14x, r1_d14y, r1_d23x, r1_d23y;
    logic [3:0] r1_win;
    logic [3:0] n1_win;

    always_comb begin
        n1_win[0] = in_box(i_pts.x3, i_pts.x1, i_pts.x2) && in_box(i_pts.y3, i_pts.y1, i_pts.y2);
        n1_win[1] = in_box(i_pts.x4, i_pts.x1, i_pts.x2) && in_box(i_pts.y4, i_pts.y1, i_pts.y2);
        n1_win[2] = in_box(i_pts.x1, i_pts.x3, i_pts.x4) && in_box(i_pts.y1, i_pts.y3, i_pts.y4);
        n1_win[3] = in_box(i_pts.x2, i_pts.x3, i_pts.x4) && in_box(i_pts.y2, i_pts.y3, i_pts.y4);
    end

    // Stage 2: products
    logic       r2_valid;
    t_pts       r2_pts;
    t_diff      r2_adx, r2_ady;
    logic [3:0] r2_win;
    t_prod      r2_p1a, r2_p1b, r2_p2a, r2_p2b, r2_p3a, r2_p3b, r2_p4a, r2_p4b;
    t_prod      r2_pda, r2_pdb;

    // Stage 3: cross products
    logic       r3_valid;
    t_geo       r3_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pts  <= i_pts;
            r1_win  <= n1_win;
            r1_adx  <= t_diff'(i_pts.x2) - t_diff'(i_pts.x1);
            r1_ady  <= t_diff'(i_pts.y2) - t_diff'(i_pts.y1);
            r1_bdx  <= t_diff'(i_pts.x4) - t_diff'(i_pts.x3);
            r1_bdy  <= t_diff'(i_pts.y4) - t_diff'(i_pts.y3);
            r1_d13x <= t_diff'(i_pts.x3) - t_diff'(i_pts.x1);
            r1_d13y <= t_diff'(i_pts.y3) - t_diff'(i_pts.y1);
            r1_d14x <= t_diff'(i_pts.x4) - t_diff'(i_pts.x1);
            r1_d14y <= t_diff'(i_pts.y4) - t_diff'(i_pts.y1);
            r1_d23x <= t_diff'(i_pts.x2) - t_diff'(i_pts.x3);
            r1_d23y <= t_diff'(i_pts.y2) - t_diff'(i_pts.y3);

            r2_pts <= r1_pts;
            r2_win <= r1_win;
            r2_adx <= r1_adx;
            r2_ady <= r1_ady;
            r2_p1a <= r1_adx * r1_d13y;
            r2_p1b <= r1_ady * r1_d13x;
            r2_p2a <= r1_adx * r1_d14y;
            r2_p2b <= r1_ady * r1_d14x;
            r2_p3a <= r1_d13x * r1_bdy;
            r2_p3b <= r1_d13y * r1_bdx;
            r2_p4a <= r1_bdx * r1_d23y;
            r2_p4b <= r1_bdy * r1_d23x;
            r2_pda <= r1_adx * r1_bdy;
            r2_pdb <= r1_ady * r1_bdx;

            r3_geo.c1  <= t_cross'(r2_p1a) - t_cross'(r2_p1b);
            r3_geo.c2  <= t_cross'(r2_p2a) - t_cross'(r2_p2b);
            r3_geo.c3  <= t_cross'(r2_p3a) - t_cross'(r2_p3b);
            r3_geo.c4  <= t_cross'(r2_p4a) - t_cross'(r2_p4b);
            r3_geo.den <= t_cross'(r2_pda) - t_cross'(r2_pdb);
            r3_geo.adx <= r2_adx;
            r3_geo.ady <= r2_ady;
            r3_geo.win <= r2_win;
            r3_geo.pts <= r2_pts;
        end
    end

    assign o_valid = r3_valid;
    assign o_geo   = r3_geo;

endmodule

FILE: rtl/core/sip_interp.sv
// ----------------------------------------------------------------------------
// sip_interp: hit decision and interpolation numerators
// Three stages: classify and multiply, sum, take magnitudes for the divider.
// ----------------------------------------------------------------------------
module sip_interp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sip_pkg::t_geo      i_geo,
    output logic               o_valid,
    output sip_pkg::t_quot_req o_req
);
    import sip_pkg::*;

    // Orientation sign as {negative, zero}
    function automatic logic [1:0] sgn(input t_cross c);
        return {c[CROSS_W-1], (c == '0)};
    endfunction

    logic [1:0] w_s1, w_s2, w_s3, w_s4;
    logic       w_cross;
    t_side      n4_side;

    always_comb begin
        w_s1    = sgn(i_geo.c1);
        w_s2    = sgn(i_geo.c2);
        w_s3    = sgn(i_geo.c3);
        w_s4    = sgn(i_geo.c4);
        w_cross = (w_s1 != w_s2) && (w_s3 != w_s4);
        n4_side.ep_x = i_geo.pts.x1;
        n4_side.ep_y = i_geo.pts.y1;
        n4_side.kind = KIND_NONE;
        if (w_cross) begin
            n4_side.kind = (i_geo.den == '0) ? KIND_NONE : KIND_CROSS;
        end else if (w_s1[0] && i_geo.win[0]) begin
            n4_side.kind = KIND_B_START;
            n4_side.ep_x = i_geo.pts.x3;
            n4_side.ep_y = i_geo.pts.y3;
        end else if (w_s2[0] && i_geo.win[1]) begin
            n4_side.kind = KIND_B_END;
            n4_side.ep_x = i_geo.pts.x4;
            n4_side.ep_y = i_geo.pts.y4;
        end else if (w_s3[0] && i_geo.win[2]) begin
            n4_side.kind = KIND_A_START;
        end else if (w_s4[0] && i_geo.win[3]) begin
            n4_side.kind = KIND_A_END;
            n4_side.ep_x = i_geo.pts.x2;
            n4_side.ep_y = i_geo.pts.y2;
        end
    end

    logic      r4_valid, r5_valid, r6_valid;
    t_side     r4_side, r5_side;
    t_cross    r4_den, r5_den;
    t_psum     r4_ax, r4_bx, r4_ay, r4_by;
    t_psum     r5_nx, r5_ny;
    t_quot_req r6_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // numerator = p1 * den + tnum * (p2 - p1); tnum equals c3
            r4_side <= n4_side;
            r4_den  <= i_geo.den;
            r4_ax   <= i_geo.pts.x1 * i_geo.den;
            r4_bx   <= i_geo.c3 * i_geo.adx;
            r4_ay   <= i_geo.pts.y1 * i_geo.den;
            r4_by   <= i_geo.c3 * i_geo.ady;

            r5_side <= r4_side;
            r5_den  <= r4_den;
            r5_nx   <= r4_ax + r4_bx;
            r5_ny   <= r4_ay + r4_by;

            r6_req.side  <= r5_side;
            r6_req.mag_x <= r5_nx[PSUM_W-1] ? t_mag'(-r5_nx) : t_mag'(r5_nx);
            r6_req.mag_y <= r5_ny[PSUM_W-1] ? t_mag'(-r5_ny) : t_mag'(r5_ny);
            r6_req.neg_x <= r5_nx[PSUM_W-1] ^ r5_den[CROSS_W-1];
            r6_req.neg_y <= r5_ny[PSUM_W-1] ^ r5_den[CROSS_W-1];
            r6_req.dmag  <= r5_den[CROSS_W-1] ? t_dmag'(-r5_den) : t_dmag'(r5_den);
        end
    end

    assign o_valid = r6_valid;
    assign o_req   = r6_req;

endmodule

FILE: rtl/core/sip_div.sv
// ----------------------------------------------------------------------------
// sip_div: pipelined restoring divider, two lanes sharing one divisor
// One quotient bit per stage; the hit decision rides along.
// ----------------------------------------------------------------------------
module sip_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sip_pkg::t_quot_req i_req,
    output logic               o_valid,
    output sip_pkg::t_quot_res o_res
);
    import sip_pkg::*;

    function automatic t_lane div_init(input t_mag m);
        logic [SH_W-1:0] sh;
        t_lane           r;
        sh    = SH_W'(m) << FRAC_BITS;
        r.rem = sh[QUO_W+DMAG_W-1:QUO_W];
        r.nq  = sh[QUO_W-1:0];
        return r;
    endfunction

    function automatic t_lane div_step(input t_lane l, input t_dmag d);
        logic [DMAG_W:0] t;
        logic [DMAG_W:0] diff;
        logic            ge;
        t_lane           r;
        t     = {l.rem, l.nq[QUO_W-1]};
        diff  = t - {1'b0, d};
        ge    = (t >= {1'b0, d});
        r.rem = ge ? diff[DMAG_W-1:0] : t[DMAG_W-1:0];
        r.nq  = {l.nq[QUO_W-2:0], ge};
        return r;
    endfunction

    t_div_st w_in  [QUO_W];
    logic    w_vin [QUO_W];
    t_div_st r_st  [QUO_W];
    logic    r_vld [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        if (k == 0) begin : g_head
            assign w_in[k].x     = div_init(i_req.mag_x);
            assign w_in[k].y     = div_init(i_req.mag_y);
            assign w_in[k].dmag  = i_req.dmag;
            assign w_in[k].neg_x = i_req.neg_x;
            assign w_in[k].neg_y = i_req.neg_y;
            assign w_in[k].side  = i_req.side;
            assign w_vin[k]      = i_valid;
        end else begin : g_link
            assign w_in[k]  = r_st[k-1];
            assign w_vin[k] = r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k].x     <= div_step(w_in[k].x, w_in[k].dmag);
                r_st[k].y     <= div_step(w_in[k].y, w_in[k].dmag);
                r_st[k].dmag  <= w_in[k].dmag;
                r_st[k].neg_x <= w_in[k].neg_x;
                r_st[k].neg_y <= w_in[k].neg_y;
                r_st[k].side  <= w_in[k].side;
            end
        end
    end

    assign o_valid      = r_vld[QUO_W-1];
    assign o_res.quot_x = r_st[QUO_W-1].x.nq;
    assign o_res.quot_y = r_st[QUO_W-1].y.nq;
    assign o_res.neg_x  = r_st[QUO_W-1].neg_x;
    assign o_res.neg_y  = r_st[QUO_W-1].neg_y;
    assign o_res.side   = r_st[QUO_W-1].side;

endmodule
